// File: design/rgbi_pkg.sv
// Package for the RGB to I420 colour converter: register indexes,
// field widths and the fixed BT.601 limited-range coefficients.
// No dependencies.
`default_nettype none

package rgbi_pkg;

    localparam int ByteW    = 8;
    localparam int WidthW   = 13;
    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 16;
    localparam int SumW     = 16;

    localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_RGB_ORDER  = 8'd1;

    localparam logic [WidthW-1:0] LINE_WIDTH_RESET = 13'd640;
    localparam logic [WidthW-1:0] LINE_WIDTH_MIN   = 13'd2;

    localparam logic [SumW-1:0] COEF_Y_R  = 16'd66;
    localparam logic [SumW-1:0] COEF_Y_G  = 16'd129;
    localparam logic [SumW-1:0] COEF_Y_B  = 16'd25;
    localparam logic [SumW-1:0] COEF_CB_B = 16'd56;
    localparam logic [SumW-1:0] COEF_CB_R = 16'd19;
    localparam logic [SumW-1:0] COEF_CB_G = 16'd37;
    localparam logic [SumW-1:0] COEF_CR_R = 16'd56;
    localparam logic [SumW-1:0] COEF_CR_G = 16'd47;
    localparam logic [SumW-1:0] COEF_CR_B = 16'd9;

    localparam logic [SumW-1:0]  CHROMA_BIAS = 16'd14336;
    localparam logic [ByteW-1:0] LUMA_OFFSET = 8'd16;
    localparam logic [ByteW-1:0] CHROMA_BASE = 8'd16;

    typedef struct packed {
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
        logic             chroma_en;
    } pixel_t;

    typedef struct packed {
        logic [ByteW-1:0] luma;
        logic             chroma_valid;
        logic [ByteW-1:0] chroma_blue;
        logic [ByteW-1:0] chroma_red;
    } result_t;

endpackage

`default_nettype wire

// File: design/rgbi_pixel_math.sv
// Colour matrix for one pixel: luma always, Cb and Cr when chroma is enabled.
// Depends on rgbi_pkg.
`default_nettype none

module rgbi_pixel_math (
    input  var rgbi_pkg::pixel_t  pixel,
    output var rgbi_pkg::result_t result
);
    import rgbi_pkg::*;

    logic [SumW-1:0] y_sum;
    logic [SumW-1:0] cb_sum;
    logic [SumW-1:0] cr_sum;

    always_comb begin
        y_sum = COEF_Y_R * SumW'(pixel.red) + COEF_Y_G * SumW'(pixel.green)
              + COEF_Y_B * SumW'(pixel.blue);
        cb_sum = COEF_CB_B * SumW'(pixel.blue) + CHROMA_BIAS
               - COEF_CB_R * SumW'(pixel.red) - COEF_CB_G * SumW'(pixel.green);
        cr_sum = COEF_CR_R * SumW'(pixel.red) + CHROMA_BIAS
               - COEF_CR_G * SumW'(pixel.green) - COEF_CR_B * SumW'(pixel.blue);

        result.luma         = y_sum[SumW-1:ByteW] + LUMA_OFFSET;
        result.chroma_valid = pixel.chroma_en;
        if (pixel.chroma_en) begin
            result.chroma_blue = cb_sum[ByteW+6:7] + CHROMA_BASE;
            result.chroma_red  = cr_sum[ByteW+6:7] + CHROMA_BASE;
        end else begin
            result.chroma_blue = '0;
            result.chroma_red  = '0;
        end
    end

endmodule

`default_nettype wire

// File: design/rgb_to_i420_color_convert.sv
// RGB to I420 colour converter top level: config registers, raster position
// tracking, input register, colour matrix and output register.
// An accepted input is held in the input register, then its result in the output register.
// Throughput is one pixel per cycle, limited only by the output handshake.
// Reset (aresetn low, synchronous) empties both stages, clears the column
// counter and row parity, and sets line_width to 640 and rgb_order to 1.
// Depends on rgbi_pkg and rgbi_pixel_math.
`default_nettype none

module rgb_to_i420_color_convert #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // first_byte [7:0], green_byte [15:8], third_byte [23:16]
    input  wire  [23:0]                  s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
    output logic [23:0]                  m_tdata,
    // chroma_valid [0]
    output logic [0:0]                   m_tuser,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [rgbi_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire  [rgbi_pkg::CfgDataW-1:0] cfg_data
);
    import rgbi_pkg::*;

    localparam int CntW = $clog2(MAX_LINE_WIDTH);
    localparam int CmpW = ($clog2(MAX_LINE_WIDTH + 1) > WidthW) ?
                          $clog2(MAX_LINE_WIDTH + 1) : WidthW;
    localparam logic [CmpW-1:0] MaxWidth = CmpW'(MAX_LINE_WIDTH);

    logic [WidthW-1:0] line_width_reg;
    logic              rgb_order_reg;
    logic [CntW-1:0]   column_count_reg, column_count_next;
    logic              odd_row_reg, odd_row_next;
    logic              stage_valid_reg;
    pixel_t            stage_reg, stage_next;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           math_result;
    logic              out_free;
    logic              s_accept;
    logic [CmpW-1:0]   eff_width;
    logic [CmpW-1:0]   column_plus_one;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !stage_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;

    always_comb begin
        eff_width = CmpW'(line_width_reg);
        if (line_width_reg < LINE_WIDTH_MIN) begin
            eff_width = CmpW'(LINE_WIDTH_MIN);
        end else if (eff_width > MaxWidth) begin
            eff_width = MaxWidth;
        end
        column_plus_one = CmpW'(column_count_reg) + CmpW'(1);
        if (column_plus_one >= eff_width) begin
            column_count_next = '0;
            odd_row_next      = !odd_row_reg;
        end else begin
            column_count_next = column_plus_one[CntW-1:0];
            odd_row_next      = odd_row_reg;
        end

        stage_next.green     = s_tdata[15:8];
        stage_next.red       = rgb_order_reg ? s_tdata[7:0] : s_tdata[23:16];
        stage_next.blue      = rgb_order_reg ? s_tdata[23:16] : s_tdata[7:0];
        stage_next.chroma_en = !odd_row_reg && !column_count_reg[0];
    end

    rgbi_pixel_math u_math (
        .pixel  (stage_reg),
        .result (math_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RESET;
            rgb_order_reg    <= 1'b1;
            column_count_reg <= '0;
            odd_row_reg      <= 1'b0;
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_LINE_WIDTH) begin
                    line_width_reg <= cfg_data[WidthW-1:0];
                end else if (cfg_index == REG_RGB_ORDER) begin
                    rgb_order_reg <= cfg_data[0];
                end
            end
            if (s_accept) begin
                column_count_reg <= column_count_next;
                odd_row_reg      <= odd_row_next;
            end
            if (s_tready) begin
                stage_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_reg <= stage_next;
        end
        if (out_free && stage_valid_reg) begin
            out_reg <= math_result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_reg.chroma_red, out_reg.chroma_blue, out_reg.luma};
    assign m_tuser[0] = out_reg.chroma_valid;

`ifndef NO_ASSERTIONS
    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235))
        else $error("Luma outside the limited range.");

    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[23:8] == 16'd0))
        else $error("Chroma not zero on a result without chroma.");

    a_chroma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:8] >= 8'd16 && m_tdata[15:8] <= 8'd239
            && m_tdata[23:16] >= 8'd16 && m_tdata[23:16] <= 8'd239))
        else $error("Chroma outside the limited range.");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("Input accepted while both stages are held.");
`endif

endmodule

`default_nettype wire

// File: bench/tb_rgb_to_i420_color_convert.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_i420_color_convert: streams random and corner
// pixels under changing line widths and byte orders and checks every Y/Cb/Cr sample.
// Depends on rgbi_pkg and the converter RTL.

module tb_rgb_to_i420_color_convert;

    import rgbi_pkg::*;

    localparam int MaxLineWidth = 4096;

    localparam logic [23:0] CornerPixels [0:7] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
        24'hFF0000, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF
    };

    class i420_sample_board;
        logic [WidthW-1:0] line_width;
        logic              rgb_order;
        int unsigned       column_count;
        logic              odd_row;
        result_t           pending_samples [$];
        int                errors;
        int                checked;
        int                chroma_count;

        function new();
            line_width   = LINE_WIDTH_RESET;
            rgb_order    = 1'b1;
            column_count = 0;
            odd_row      = 1'b0;
            errors       = 0;
            checked      = 0;
            chroma_count = 0;
        endfunction

        function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            if (idx == REG_LINE_WIDTH) begin
                line_width = data[WidthW-1:0];
            end else if (idx == REG_RGB_ORDER) begin
                rgb_order = data[0];
            end
        endfunction

        function void note_pixel(logic [23:0] d);
            int      red;
            int      green;
            int      blue;
            int      span;
            int      cb_sum;
            int      cr_sum;
            result_t s;
            red   = rgb_order ? d[7:0] : d[23:16];
            green = d[15:8];
            blue  = rgb_order ? d[23:16] : d[7:0];
            s.luma         = 8'(((66 * red + 129 * green + 25 * blue) >> 8) + 16);
            s.chroma_valid = !odd_row && (column_count % 2 == 0);
            s.chroma_blue  = 8'd0;
            s.chroma_red   = 8'd0;
            if (s.chroma_valid) begin
                // The offset keeps both sums positive so the shift is a floor.
                cb_sum = 56 * blue + 14336 - 19 * red - 37 * green;
                cr_sum = 56 * red + 14336 - 47 * green - 9 * blue;
                s.chroma_blue = 8'((cb_sum >> 7) + 16);
                s.chroma_red  = 8'((cr_sum >> 7) + 16);
                chroma_count++;
            end
            span = line_width;
            if (span < 2) span = 2;
            if (span > MaxLineWidth) span = MaxLineWidth;
            if (column_count + 1 >= span) begin
                column_count = 0;
                odd_row      = ~odd_row;
            end else begin
                column_count++;
            end
            pending_samples.push_back(s);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("%s", msg);
        endtask

        task compare_field(string field, int got, int want);
            if (got != want) begin
                report($sformatf("sample %0d: %s is %0d, expected %0d", checked, field, got, want));
            end
        endtask

        task check_sample(logic [23:0] data, logic user);
            result_t want;
            if (pending_samples.size() == 0) begin
                report($sformatf("sample with no pixel outstanding: data %h user %b", data, user));
                return;
            end
            want = pending_samples.pop_front();
            compare_field("luma", data[7:0], want.luma);
            compare_field("chroma_valid", user, want.chroma_valid);
            compare_field("chroma_blue", data[15:8], want.chroma_blue);
            compare_field("chroma_red", data[23:16], want.chroma_red);
            checked++;
        endtask

        function int pending();
            return pending_samples.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    i420_sample_board board;
    int               hold_requests = 0;
    int               holds_done    = 0;
    int               setting_count = 0;

    rgb_to_i420_color_convert #(
        .MAX_LINE_WIDTH(MaxLineWidth)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) board.note_pixel(s_tdata);
            if (m_tvalid && m_tready) board.check_sample(m_tdata, m_tuser[0]);
        end
    end

    initial begin : receiver
        int mode;
        int stretch;
        int step;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
            end else begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(8, 48);
                for (step = 0; step < stretch; step++) begin
                    if (hold_requests != holds_done) break;
                    case (mode)
                        0: begin
                            m_tready <= 1'b1;
                        end
                        1: begin
                            m_tready <= ($urandom_range(0, 3) != 0);
                        end
                        2: begin
                            m_tready <= ($urandom_range(0, 3) == 0);
                        end
                        default: begin
                            m_tready <= (step % 5 != 4);
                        end
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        int          k;
        p = 24'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            for (k = 0; k < 3; k++) begin
                case ($urandom_range(0, 2))
                    0: p[k*8 +: 8] = 8'h00;
                    1: p[k*8 +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return p;
    endfunction

    function automatic int pick_width();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 2 * $urandom_range(1, 8);
            4, 5: return 2 * $urandom_range(1, 15) + 1;
            6: return $urandom_range(0, 8191);
            7: begin
                case ($urandom_range(0, 4))
                    0: return 0;
                    1: return 1;
                    2: return 4095;
                    3: return 4096;
                    default: return 8191;
                endcase
            end
            default: return ($urandom_range(0, 1) == 1) ? 640 : 2 * $urandom_range(16, 32);
        endcase
    endfunction

    task automatic push_pixel(input logic [23:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_input(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        pause_input(1);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input int width_value, input bit order, input bit stray);
        wait_drained();
        write_reg(REG_LINE_WIDTH, {3'($urandom), 13'(width_value)});
        write_reg(REG_RGB_ORDER, {15'($urandom), order});
        if (stray) write_reg(8'($urandom_range(2, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        setting_count++;
    endtask

    task automatic send_run(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) push_pixel(rand_pixel());
            left -= burst;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) pause_input(gap);
        end
    endtask

    initial begin : stimulus
        int phase;
        int items;
        int guard;
        board = new();
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (CornerPixels[i]) push_pixel(CornerPixels[i]);
        configure(3, 1'b0, 1'b0);
        foreach (CornerPixels[i]) push_pixel(CornerPixels[i]);
        configure(0, 1'b1, 1'b1);
        repeat (3) push_pixel(rand_pixel());
        configure(8191, 1'b0, 1'b0);
        repeat (2) push_pixel(rand_pixel());
        configure(1, 1'b1, 1'b0);
        repeat (2) push_pixel(rand_pixel());

        for (phase = 0; phase < 8; phase++) begin
            configure(pick_width(), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
            items = $urandom_range(75, 105);
            if (phase == 0) begin
                hold_requests++;
                send_run(items / 2);
                wait_drained();
                send_run(items - items / 2);
            end else begin
                send_run(items);
            end
        end

        pause_input(1);
        guard = 0;
        while (board.pending() != 0 && guard < 4000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (board.pending() != 0) begin
            board.report($sformatf("%0d samples never arrived", board.pending()));
        end

        $display("Checked %0d samples, %0d of them with chroma, over %0d register settings.",
                 board.checked, board.chroma_count, setting_count + 1);
        $display("Widths spanned both clamps and odd values, in both byte orders.");
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
design/rgbi_pkg.sv
design/rgbi_pixel_math.sv
design/rgb_to_i420_color_convert.sv
bench/tb_rgb_to_i420_color_convert.sv
